@@ rtl/core/lsegt_pkg.sv @@
package lsegt_pkg;

  localparam int unsigned MAX_LEAVES = 1024;
  localparam int unsigned NODE_COUNT = 4 * MAX_LEAVES;
  localparam int unsigned LEAF_AW    = $clog2(MAX_LEAVES);
  localparam int unsigned NODE_AW    = $clog2(NODE_COUNT);
  localparam int unsigned STACK_D    = 16;
  localparam int unsigned SP_W       = $clog2(STACK_D);

  localparam logic [2:0] FN_CLEAR = 3'd0;
  localparam logic [2:0] FN_LEAF  = 3'd1;
  localparam logic [2:0] FN_BUILD = 3'd2;
  localparam logic [2:0] FN_ADD   = 3'd3;
  localparam logic [2:0] FN_SUM   = 3'd4;

  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_JOIN  = 2'd2;

  typedef struct packed {
    logic [31:0] pend;
    logic [31:0] sum;
  } node_t;

  typedef struct packed {
    logic [NODE_AW:0]    k;
    logic [LEAF_AW-1:0]  b;
    logic [LEAF_AW-1:0]  e;
    logic [1:0]          ph;
  } frame_t;

endpackage

@@ rtl/core/lazy_segment_tree_range_add_sum_top.sv @@
// a leaf write goes into the leaf memory while idle; clear zeroes every node; build loads leaf
// nodes from the leaf memory and sums inner nodes; range add or query visits nodes (read, push
// of a pending add into both children, recombine on an add) over separate node read/write ports
// throughput: one request at a time, the next is taken once busy_o falls
// reset: every node of the node memory is swept to zero, busy_o high meanwhile
// a query result is shown on done_o for one cycle; the receiver cannot stall
module lazy_segment_tree_range_add_sum_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [2:0]                        func_i,
  input  logic [lsegt_pkg::LEAF_AW-1:0]     range_low_i,
  input  logic [lsegt_pkg::LEAF_AW-1:0]     range_high_i,
  input  logic signed [31:0]                operand_value_i,
  output logic                              done_o,
  output logic signed [31:0]                range_sum_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lsegt_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_CLR   = 5'd1;
  localparam logic [4:0] ST_ENTER = 5'd2;
  localparam logic [4:0] ST_GOTD  = 5'd3;
  localparam logic [4:0] ST_PW    = 5'd4;
  localparam logic [4:0] ST_C0R   = 5'd5;
  localparam logic [4:0] ST_C0W   = 5'd6;
  localparam logic [4:0] ST_C1R   = 5'd7;
  localparam logic [4:0] ST_C1W   = 5'd8;
  localparam logic [4:0] ST_CHK   = 5'd9;
  localparam logic [4:0] ST_POP   = 5'd10;
  localparam logic [4:0] ST_RET   = 5'd11;
  localparam logic [4:0] ST_FR0   = 5'd12;
  localparam logic [4:0] ST_FR1   = 5'd13;
  localparam logic [4:0] ST_FR2   = 5'd14;
  localparam logic [4:0] ST_FR3   = 5'd15;
  localparam logic [4:0] ST_BL0   = 5'd16;
  localparam logic [4:0] ST_BL1   = 5'd17;

  logic [4:0]          state_q, state_d, nxt_q, nxt_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  frame_t              stk_q [STACK_D];
  frame_t              stk_d [STACK_D];
  logic [2:0]          func_q, func_d;
  logic [LEAF_AW-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [31:0]         v_q, v_d, s_q, s_d, p_q, p_d, prod_q, prod_d, sl_q, sl_d;
  logic [31:0]         acc_q, acc_d, rsum_q, rsum_d;
  logic                done_q, done_d;
  logic [NODE_AW-1:0]  clr_q, clr_d;
  logic [10:0]         alen_q;

  node_t               node_mem [NODE_COUNT];
  logic [31:0]         leaf_mem [MAX_LEAVES];
  node_t               node_rd, node_wd;
  logic [31:0]         leaf_rd;
  logic                node_we, node_re, leaf_we, leaf_re;
  logic [NODE_AW-1:0]  node_wa, node_ra;

  logic                accept;
  logic [LEAF_AW-1:0]  last;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign range_sum_o = rsum_q;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {21'd0, alen_q};

  always_comb begin
    if (alen_q == 11'd0) begin
      last = '0;
    end else if (alen_q > 11'(MAX_LEAVES)) begin
      last = LEAF_AW'(MAX_LEAVES - 1);
    end else begin
      last = LEAF_AW'(alen_q - 11'd1);
    end
  end

  always_comb begin
    frame_t              top;
    logic                kin, hasc;
    logic [NODE_AW-1:0]  ka, kl, kr;
    logic [LEAF_AW:0]    len;
    logic [LEAF_AW-1:0]  mid;
    logic [LEAF_AW:0]    bsum;
    logic                disj, cov;
    logic [31:0]         mul_p;
    logic                do_mul;

    state_d = state_q;
    nxt_d   = nxt_q;
    sp_d    = sp_q;
    stk_d   = stk_q;
    func_d  = func_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    v_d     = v_q;
    s_d     = s_q;
    p_d     = p_q;
    prod_d  = prod_q;
    sl_d    = sl_q;
    acc_d   = acc_q;
    rsum_d  = rsum_q;
    done_d  = 1'b0;
    clr_d   = clr_q;
    node_we = 1'b0;
    node_re = 1'b0;
    node_wa = '0;
    node_ra = '0;
    node_wd = '0;
    leaf_re = 1'b0;
    leaf_we = accept && (func_i == FN_LEAF);

    top    = stk_q[sp_q];
    kin    = (top.k[NODE_AW] == 1'b0);
    hasc   = (top.b != top.e) && (top.k[NODE_AW:NODE_AW-1] == 2'b00);
    ka     = top.k[NODE_AW-1:0];
    kl     = {top.k[NODE_AW-2:0], 1'b0};
    kr     = {top.k[NODE_AW-2:0], 1'b1};
    len    = {1'b0, top.e} - {1'b0, top.b} + 1'b1;
    bsum   = {1'b0, top.b} + {1'b0, top.e};
    mid    = bsum[LEAF_AW:1];
    disj   = (top.b > hi_q) || (top.e < lo_q);
    cov    = (top.b >= lo_q) && (top.e <= hi_q);
    mul_p  = (state_q == ST_GOTD) ? node_rd.pend : v_q;
    do_mul = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d   = func_i;
          lo_d     = range_low_i;
          hi_d     = range_high_i;
          v_d      = operand_value_i;
          acc_d    = '0;
          sp_d     = '0;
          stk_d[0] = '{k: (NODE_AW+1)'(1), b: '0, e: last, ph: PH_LEFT};
          priority case (func_i)
            FN_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLR;
            end
            FN_BUILD, FN_ADD, FN_SUM: state_d = ST_ENTER;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        node_we = 1'b1;
        node_wa = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == NODE_AW'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_ENTER: begin
        if (!kin) begin
          state_d = ST_POP;
        end else if (func_q == FN_BUILD) begin
          if (top.b == top.e) begin
            state_d = ST_BL0;
          end else begin
            stk_d[sp_q].ph = PH_RIGHT;
            stk_d[sp_q + 1'b1] = '{k: {top.k[NODE_AW-1:0], 1'b0}, b: top.b, e: mid,
                                   ph: PH_LEFT};
            sp_d = sp_q + 1'b1;
          end
        end else begin
          node_re = 1'b1;
          node_ra = ka;
          state_d = ST_GOTD;
        end
      end
      ST_GOTD: begin
        s_d = node_rd.sum;
        if (node_rd.pend != 32'd0) begin
          p_d     = node_rd.pend;
          do_mul  = 1'b1;
          nxt_d   = ST_CHK;
          state_d = ST_PW;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_PW: begin
        node_we = 1'b1;
        node_wa = ka;
        node_wd = '{pend: 32'd0, sum: s_q + prod_q};
        s_d     = s_q + prod_q;
        state_d = hasc ? ST_C0R : nxt_q;
      end
      ST_C0R: begin
        node_re = 1'b1;
        node_ra = kl;
        state_d = ST_C0W;
      end
      ST_C0W: begin
        node_we = 1'b1;
        node_wa = kl;
        node_wd = '{pend: node_rd.pend + p_q, sum: node_rd.sum};
        state_d = ST_C1R;
      end
      ST_C1R: begin
        node_re = 1'b1;
        node_ra = kr;
        state_d = ST_C1W;
      end
      ST_C1W: begin
        node_we = 1'b1;
        node_wa = kr;
        node_wd = '{pend: node_rd.pend + p_q, sum: node_rd.sum};
        state_d = nxt_q;
      end
      ST_CHK: begin
        if (disj) begin
          state_d = ST_POP;
        end else if (cov) begin
          if (func_q == FN_SUM) begin
            acc_d   = acc_q + s_q;
            state_d = ST_POP;
          end else if (v_q != 32'd0) begin
            p_d     = v_q;
            do_mul  = 1'b1;
            nxt_d   = ST_POP;
            state_d = ST_PW;
          end else begin
            state_d = ST_POP;
          end
        end else begin
          stk_d[sp_q].ph = PH_RIGHT;
          stk_d[sp_q + 1'b1] = '{k: {top.k[NODE_AW-1:0], 1'b0}, b: top.b, e: mid,
                                 ph: PH_LEFT};
          sp_d    = sp_q + 1'b1;
          state_d = ST_ENTER;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          if (func_q == FN_SUM) begin
            done_d = 1'b1;
            rsum_d = acc_q;
          end
          state_d = ST_IDLE;
        end else begin
          sp_d    = sp_q - 1'b1;
          state_d = ST_RET;
        end
      end
      ST_RET: begin
        if (top.ph == PH_RIGHT) begin
          stk_d[sp_q].ph = PH_JOIN;
          stk_d[sp_q + 1'b1] = '{k: {top.k[NODE_AW-1:0], 1'b1},
                                 b: mid + 1'b1, e: top.e, ph: PH_LEFT};
          sp_d    = sp_q + 1'b1;
          state_d = ST_ENTER;
        end else if ((func_q != FN_SUM) && hasc) begin
          state_d = ST_FR0;
        end else begin
          state_d = ST_POP;
        end
      end
      ST_FR0: begin
        node_re = 1'b1;
        node_ra = kl;
        state_d = ST_FR1;
      end
      ST_FR1: begin
        sl_d    = node_rd.sum;
        node_re = 1'b1;
        node_ra = kr;
        state_d = ST_FR2;
      end
      ST_FR2: begin
        sl_d    = sl_q + node_rd.sum;
        node_re = 1'b1;
        node_ra = ka;
        state_d = ST_FR3;
      end
      ST_FR3: begin
        node_we = 1'b1;
        node_wa = ka;
        node_wd = '{pend: node_rd.pend, sum: sl_q};
        state_d = ST_POP;
      end
      ST_BL0: begin
        leaf_re = 1'b1;
        node_re = 1'b1;
        node_ra = ka;
        state_d = ST_BL1;
      end
      ST_BL1: begin
        node_we = 1'b1;
        node_wa = ka;
        node_wd = '{pend: node_rd.pend, sum: leaf_rd};
        state_d = ST_POP;
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_mul) begin
      prod_d = {21'd0, len} * mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      nxt_q   <= ST_IDLE;
      sp_q    <= '0;
      func_q  <= FN_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      alen_q  <= 11'(MAX_LEAVES);
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      sp_q    <= sp_d;
      func_q  <= func_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (psel && penable && pwrite && !paddr[2]) begin
        alen_q <= pwdata[10:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stk_q  <= stk_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    v_q    <= v_d;
    s_q    <= s_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    sl_q   <= sl_d;
    acc_q  <= acc_d;
    rsum_q <= rsum_d;
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (node_re) begin
      node_rd <= node_mem[node_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[range_low_i] <= operand_value_i;
    end
    if (leaf_re) begin
      leaf_rd <= leaf_mem[stk_q[sp_q].b];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> func_q == FN_SUM)
    else $error("result strobe outside a query");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("more than one result for a query");
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SP_W'(11))
    else $error("walk stack too deep");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_we && node_re |-> node_wa != node_ra)
    else $error("node memory read and write collide");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_POP)
    else $error("result not at end of walk");

endmodule

@@ tb/sv/lazy_segment_tree_range_add_sum_top_tb.sv @@
module lazy_segment_tree_range_add_sum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsegt_pkg::*;

  localparam logic [2:0] FN_SPARE_FIRST    = 3'd5;
  localparam logic [2:0] FN_SPARE_LAST     = 3'd7;
  localparam logic [2:0] REG_ACTIVE_LENGTH = 3'd0;
  localparam int unsigned LEN_MASK         = 32'h7FF;

  typedef logic [LEAF_AW-1:0] idx_t;

  typedef struct {
    logic [2:0]  func;
    idx_t        lo;
    idx_t        hi;
    logic [31:0] value;
    bit          fixed;
    logic [31:0] fixed_sum;
  } req_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [2:0]         func_i;
  idx_t               range_low_i;
  idx_t               range_high_i;
  logic signed [31:0] operand_value_i;
  logic               done_o;
  logic signed [31:0] range_sum_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // shadow of the block state
  bit [31:0]   tree_sum [NODE_COUNT];
  bit [31:0]   tree_pend [NODE_COUNT];
  bit [31:0]   leaf_val [MAX_LEAVES];
  bit          leaf_set [MAX_LEAVES];
  int unsigned cfg_length;

  logic [31:0] sum_queue [$];
  int          errors;

  lazy_segment_tree_range_add_sum_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .range_low_i     (range_low_i),
    .range_high_i    (range_high_i),
    .operand_value_i (operand_value_i),
    .done_o          (done_o),
    .range_sum_o     (range_sum_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned tree_len();
    int unsigned n;
    n = cfg_length;
    if (n < 1) n = 1;
    if (n > MAX_LEAVES) n = MAX_LEAVES;
    return n;
  endfunction

  function automatic void settle_node(int unsigned k, int unsigned b, int unsigned e);
    bit [31:0] p;
    p = tree_pend[k];
    if (p == 0) return;
    tree_sum[k] += (e - b + 1) * p;
    if (b != e && 2 * k + 1 < NODE_COUNT) begin
      tree_pend[2 * k] += p;
      tree_pend[2 * k + 1] += p;
    end
    tree_pend[k] = 0;
  endfunction

  function automatic void build_tree(int unsigned k, int unsigned b, int unsigned e);
    int unsigned mid;
    if (k >= NODE_COUNT) return;
    if (b == e) begin
      tree_sum[k] = leaf_val[b];
      return;
    end
    mid = (b + e) / 2;
    build_tree(2 * k, b, mid);
    build_tree(2 * k + 1, mid + 1, e);
    if (2 * k + 1 < NODE_COUNT) tree_sum[k] = tree_sum[2 * k] + tree_sum[2 * k + 1];
  endfunction

  function automatic void add_range(int unsigned k, int unsigned b, int unsigned e,
                                    int unsigned lo, int unsigned hi, bit [31:0] v);
    int unsigned mid;
    if (k >= NODE_COUNT) return;
    settle_node(k, b, e);
    if (b > hi || e < lo) return;
    if (b >= lo && e <= hi) begin
      tree_pend[k] += v;
      settle_node(k, b, e);
      return;
    end
    mid = (b + e) / 2;
    add_range(2 * k, b, mid, lo, hi, v);
    add_range(2 * k + 1, mid + 1, e, lo, hi, v);
    if (2 * k + 1 < NODE_COUNT) tree_sum[k] = tree_sum[2 * k] + tree_sum[2 * k + 1];
  endfunction

  function automatic bit [31:0] sum_range(int unsigned k, int unsigned b, int unsigned e,
                                          int unsigned lo, int unsigned hi);
    int unsigned mid;
    if (k >= NODE_COUNT) return 0;
    settle_node(k, b, e);
    if (b > hi || e < lo) return 0;
    if (b >= lo && e <= hi) return tree_sum[k];
    mid = (b + e) / 2;
    return sum_range(2 * k, b, mid, lo, hi) + sum_range(2 * k + 1, mid + 1, e, lo, hi);
  endfunction

  // returns 1 and the sum when the request yields a result
  function automatic bit apply_request(logic [2:0] func, idx_t lo, idx_t hi,
                                       logic [31:0] v, output logic [31:0] sum);
    int unsigned last;
    last = tree_len() - 1;
    sum = '0;
    case (func)
      FN_CLEAR: begin
        foreach (tree_sum[i]) begin
          tree_sum[i] = 0;
          tree_pend[i] = 0;
        end
      end
      FN_LEAF: begin
        leaf_val[lo] = v;
        leaf_set[lo] = 1'b1;
      end
      FN_BUILD: build_tree(1, 0, last);
      FN_ADD:   add_range(1, 0, last, lo, hi, v);
      FN_SUM: begin
        sum = sum_range(1, 0, last, lo, hi);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int first_unset_leaf();
    for (int i = 0; i < tree_len(); i++) if (!leaf_set[i]) return i;
    return -1;
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (errors < 10)
      $display("%0t mismatch %s: expected %h actual %h", $realtime, what, exp_v, act_v);
    errors++;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (sum_queue.size() == 0) begin
        report_mismatch("unexpected range_sum", 'x, range_sum_o);
      end else begin
        logic [31:0] exp_sum;
        exp_sum = sum_queue.pop_front();
        if (range_sum_o !== exp_sum) report_mismatch("range_sum", exp_sum, range_sum_o);
      end
    end
  end

  task automatic send_request(logic [2:0] func, idx_t lo, idx_t hi, logic [31:0] v,
                              bit fixed, logic [31:0] fixed_sum);
    int          gap;
    logic [31:0] sum;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i = 1'b1;
    func_i = func;
    range_low_i = lo;
    range_high_i = hi;
    operand_value_i = v;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (apply_request(func, lo, hi, v, sum)) sum_queue.push_back(fixed ? fixed_sum : sum);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start_i = 1'b0;
    while (sum_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_length(logic [31:0] len);
    wait_idle();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = REG_ACTIVE_LENGTH;
    pwdata = len;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    cfg_length = len & LEN_MASK;
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if ((prdata & LEN_MASK) !== cfg_length) report_mismatch("active_length", cfg_length, prdata);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(4))
      0: return $urandom_range(200) - 100;
      1: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int unsigned len;
    int unsigned top;
    int          r;
    int          unset;
    logic [2:0]  func;
    idx_t        lo;
    idx_t        hi;
    idx_t        t;
    len = tree_len();
    top = (len + 3 >= MAX_LEAVES) ? MAX_LEAVES - 1 : len + 3;
    r = $urandom_range(99);
    lo = idx_t'($urandom_range(top));
    hi = idx_t'($urandom_range(top));
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(9))
      0: begin
        lo = idx_t'($urandom);
        hi = idx_t'($urandom);
      end
      1: begin
        t = lo;
        lo = hi;
        hi = t;
      end
      default: ;
    endcase
    if (r < 3) func = FN_CLEAR;
    else if (r < 5) func = 3'($urandom_range(FN_SPARE_LAST, FN_SPARE_FIRST));
    else if (r < 25) func = FN_LEAF;
    else if (r < 30) func = FN_BUILD;
    else if (r < 62) func = FN_ADD;
    else func = FN_SUM;
    if (func == FN_LEAF && $urandom_range(4) != 0) lo = idx_t'($urandom_range(len - 1));
    if (func == FN_BUILD) begin
      unset = first_unset_leaf();
      if (unset >= 0) begin
        func = FN_LEAF;
        lo = idx_t'(unset);
      end
    end
    send_request(func, lo, hi, pick_value(), 1'b0, '0);
  endtask

  req_row_t directed_rows [] = '{
    '{FN_SUM,   10'd0,    10'd1023, 32'h0,         1'b1, 32'd0},
    '{FN_ADD,   10'd0,    10'd1023, 32'd5,         1'b0, 32'd0},
    '{FN_SUM,   10'd0,    10'd1023, 32'h0,         1'b1, 32'd40},
    '{FN_SUM,   10'd5,    10'd2,    32'h0,         1'b1, 32'd0},
    '{FN_ADD,   10'd6,    10'd1,    32'd7,         1'b0, 32'd0},
    '{FN_SUM,   10'd0,    10'd7,    32'h0,         1'b1, 32'd40},
    '{FN_ADD,   10'd0,    10'd0,    32'h7FFF_FFFF, 1'b0, 32'd0},
    '{FN_ADD,   10'd0,    10'd0,    32'd1,         1'b0, 32'd0},
    '{FN_SUM,   10'd0,    10'd0,    32'h0,         1'b0, 32'd0},
    '{FN_CLEAR, 10'd0,    10'd0,    32'h0,         1'b0, 32'd0},
    '{FN_SUM,   10'd0,    10'd7,    32'h0,         1'b1, 32'd0},
    '{FN_LEAF,  10'd0,    10'd0,    32'h7FFF_FFFF, 1'b0, 32'd0},
    '{FN_LEAF,  10'd1,    10'd0,    32'h8000_0000, 1'b0, 32'd0},
    '{FN_LEAF,  10'd2,    10'd0,    32'hFFFF_FFFF, 1'b0, 32'd0},
    '{FN_LEAF,  10'd3,    10'd0,    32'h0,         1'b0, 32'd0},
    '{FN_LEAF,  10'd4,    10'd0,    32'd11,        1'b0, 32'd0},
    '{FN_LEAF,  10'd5,    10'd0,    32'd22,        1'b0, 32'd0},
    '{FN_LEAF,  10'd6,    10'd0,    32'd33,        1'b0, 32'd0},
    '{FN_LEAF,  10'd7,    10'd0,    32'd44,        1'b0, 32'd0},
    '{FN_BUILD, 10'd0,    10'd0,    32'h0,         1'b0, 32'd0},
    '{FN_SUM,   10'd0,    10'd7,    32'h0,         1'b0, 32'd0},
    '{FN_ADD,   10'd2,    10'd5,    32'hFFFF_FFFD, 1'b0, 32'd0},
    '{FN_SPARE_FIRST, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{FN_SPARE_LAST,  10'd0,    10'd0,    32'h0,         1'b0, 32'd0},
    '{FN_SUM,   10'd1,    10'd6,    32'h0,         1'b0, 32'd0}
  };

  int unsigned phase_lengths [] = '{1, 0, 37, 300, 1024, 2047, 100, 8};

  initial begin
    errors = 0;
    cfg_length = 1024;
    foreach (tree_sum[i]) begin
      tree_sum[i] = 0;
      tree_pend[i] = 0;
    end
    foreach (leaf_set[i]) begin
      leaf_set[i] = 1'b0;
      leaf_val[i] = 0;
    end
    rst_ni = 1'b0;
    start_i = 1'b0;
    func_i = FN_CLEAR;
    range_low_i = '0;
    range_high_i = '0;
    operand_value_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_ACTIVE_LENGTH;
    pwdata = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_length(8);
    foreach (directed_rows[i])
      send_request(directed_rows[i].func, directed_rows[i].lo, directed_rows[i].hi,
                   directed_rows[i].value, directed_rows[i].fixed, directed_rows[i].fixed_sum);

    foreach (phase_lengths[p]) begin
      set_length(phase_lengths[p]);
      for (int n = 0; n < 172; n++) random_request();
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
